// File: rtl/hrlf_pkg.sv
// Shared types and constants of the HTTP request length framer.
// Used by hrlf_step, the top level and the checker. No dependencies.
package hrlf_pkg;

    // Status codes shown with every result.
    localparam logic [1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [1:0] ST_COMPLETE   = 2'd1;
    localparam logic [1:0] ST_MALFORMED  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG   = 2'd3;

    // Phases of the header line scanner.
    localparam logic [2:0] PH_NAME   = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_DIGITS = 3'd2;
    localparam logic [2:0] PH_REST   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    // Characters the scanner looks for.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    // Header name length, name index limit and the maximum byte count.
    localparam logic [3:0]  HDR_NAME_CHARS = 4'd14;
    localparam logic [3:0]  NAME_IDX_MAX   = 4'd15;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    // Running state of one request, apart from the length value.
    typedef struct packed {
        logic [15:0] byte_count;
        logic [1:0]  crlf_match;
        logic [2:0]  line_phase;
        logic [3:0]  name_index;
        logic        name_matches;
        logic        length_found;
        logic        length_bad;
        logic        headers_done;
        logic [15:0] body_start;
        logic [1:0]  final_status;
    } req_state_t;

    localparam req_state_t REQ_CLEAR = '{
        byte_count:   16'd0,
        crlf_match:   2'd0,
        line_phase:   PH_NAME,
        name_index:   4'd0,
        name_matches: 1'b1,
        length_found: 1'b0,
        length_bad:   1'b0,
        headers_done: 1'b0,
        body_start:   16'd0,
        final_status: ST_INCOMPLETE
    };

    // Lower-case header name "content-length", one character per index.
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        begin
            case (idx)
                4'd0:    ch = 8'h63;  // c
                4'd1:    ch = 8'h6F;  // o
                4'd2:    ch = 8'h6E;  // n
                4'd3:    ch = 8'h74;  // t
                4'd4:    ch = 8'h65;  // e
                4'd5:    ch = 8'h6E;  // n
                4'd6:    ch = 8'h74;  // t
                4'd7:    ch = 8'h2D;  // -
                4'd8:    ch = 8'h6C;  // l
                4'd9:    ch = 8'h65;  // e
                4'd10:   ch = 8'h6E;  // n
                4'd11:   ch = 8'h67;  // g
                4'd12:   ch = 8'h74;  // t
                4'd13:   ch = 8'h68;  // h
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

// File: rtl/http_request_length_framer.sv
// HTTP request length framer: takes one request byte per transfer and returns one status
// result per byte (incomplete, complete, malformed length or too long) with the payload
// offset and the parsed Content-Length. A transfer with tuser set starts a new request.
// The block accepts one byte every clock cycle while the result side does not stall; a
// byte waits in the input register, and the state update then loads the result register
// once that register is free. Back pressure on the result side stalls the
// input after at most two buffered bytes. The user must write max_request_bytes
// through cfg_wr_en and cfg_wr_data only while no byte is in flight; the block
// does not enforce it. Depends on hrlf_pkg, hrlf_in_reg, hrlf_step.
module http_request_length_framer #(
    parameter int LENGTH_BITS = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [15:0]            cfg_wr_data,   // max_request_bytes
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // [7:0] data_byte
    input  logic                   s_axis_tuser,  // [0] start_req
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] status, [17:2] body_offset, [17+LENGTH_BITS:18] payload_length, zero fill
    output logic [((18+LENGTH_BITS+7)/8)*8-1:0] m_axis_tdata
);
    import hrlf_pkg::*;

    localparam int OUT_BITS = ((18 + LENGTH_BITS + 7) / 8) * 8;
    localparam int PAD_BITS = OUT_BITS - 18 - LENGTH_BITS;

    logic                   item_valid;
    logic [7:0]             item_byte;
    logic                   item_start;
    logic                   out_ready;
    logic                   take;
    logic [15:0]            max_bytes_reg;
    req_state_t             state_reg;
    req_state_t             state_next;
    logic [LENGTH_BITS-1:0] length_reg;
    logic [LENGTH_BITS-1:0] length_next;
    logic [1:0]             status;
    logic [15:0]            body_offset;
    logic [LENGTH_BITS-1:0] payload_length;
    logic                   m_valid_reg;
    logic [OUT_BITS-1:0]    m_data_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= 16'd4096;
        end
        else if (cfg_wr_en)
        begin
            max_bytes_reg <= cfg_wr_data;
        end
    end

    // The result register frees up when empty or when its transfer completes.
    assign out_ready = !m_valid_reg || m_axis_tready;
    assign take      = item_valid && out_ready;

    hrlf_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .take          (take),
        .item_valid    (item_valid),
        .item_byte     (item_byte),
        .item_start    (item_start)
    );

    hrlf_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .cur_state         (state_reg),
        .cur_length        (length_reg),
        .data_byte         (item_byte),
        .start_req         (item_start),
        .max_request_bytes (max_bytes_reg),
        .next_state        (state_next),
        .next_length       (length_next),
        .status            (status),
        .body_offset       (body_offset),
        .payload_length    (payload_length)
    );

    // Request state, updated once per byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= REQ_CLEAR;
            length_reg <= '0;
        end
        else if (take)
        begin
            state_reg  <= state_next;
            length_reg <= length_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            m_valid_reg <= item_valid;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            m_data_reg <= {{PAD_BITS{1'b0}}, payload_length, body_offset, status};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// File: rtl/hrlf_in_reg.sv
// Input register of the HTTP request length framer.
// Holds one accepted transfer until the update stage takes it. No dependencies.
module hrlf_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] start_req
    input  logic       take,
    output logic       item_valid,
    output logic [7:0] item_byte,
    output logic       item_start
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       start_reg;

    // The slot can refill in the same cycle it is emptied.
    assign s_axis_tready = !valid_reg || take;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            byte_reg  <= s_axis_tdata;
            start_reg <= s_axis_tuser;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_start = start_reg;

endmodule

// File: rtl/hrlf_step.sv
// Per-byte update of the HTTP request framing state and the result fields.
// Pure combinational logic; depends on hrlf_pkg.
module hrlf_step #(
    parameter int LENGTH_BITS = 20
) (
    input  hrlf_pkg::req_state_t     cur_state,
    input  logic [LENGTH_BITS-1:0]   cur_length,
    input  logic [7:0]               data_byte,
    input  logic                     start_req,
    input  logic [15:0]              max_request_bytes,
    output hrlf_pkg::req_state_t     next_state,
    output logic [LENGTH_BITS-1:0]   next_length,
    output logic [1:0]               status,
    output logic [15:0]              body_offset,
    output logic [LENGTH_BITS-1:0]   payload_length
);
    import hrlf_pkg::*;

    // Width of the sum of payload offset and length.
    localparam int NEED_BITS = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;

    req_state_t             s;
    req_state_t             ns;
    logic [LENGTH_BITS-1:0] lv;
    logic [LENGTH_BITS-1:0] nlv;
    logic                   prev_cr;
    logic                   line_end;
    logic                   is_digit;
    logic [7:0]             lower;
    logic [3:0]             digit;
    logic [LENGTH_BITS+3:0] times_ten;
    logic [NEED_BITS-1:0]   need;

    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign digit    = data_byte[3:0];
    assign lower    = ((data_byte >= CH_UP_A) && (data_byte <= CH_UP_Z))
                      ? (data_byte + 8'd32) : data_byte;

    // Running length times ten plus the new digit, before saturation.
    assign times_ten = {1'b0, lv, 3'b000} + {3'b000, lv, 1'b0}
                     + {{LENGTH_BITS{1'b0}}, digit};

    always_comb
    begin
        s        = start_req ? REQ_CLEAR : cur_state;
        lv       = start_req ? '0 : cur_length;
        ns       = s;
        nlv      = lv;
        prev_cr  = (s.crlf_match == 2'd1) || (s.crlf_match == 2'd3);
        line_end = (data_byte == CH_LF) && prev_cr;
        need     = '0;

        // A terminal status freezes everything until the next request.
        if (s.final_status == ST_INCOMPLETE)
        begin
            if (s.byte_count != COUNT_MAX)
            begin
                ns.byte_count = s.byte_count + 16'd1;
            end

            if (!s.headers_done)
            begin
                // Header line scanner.
                unique case (s.line_phase)
                    PH_NAME:
                    begin
                        if (line_end)
                        begin
                            // Only the CR was seen on this line: blank line.
                            if (s.name_index == 4'd1)
                            begin
                                ns.line_phase = PH_DONE;
                            end
                            else
                            begin
                                ns.name_index   = 4'd0;
                                ns.name_matches = 1'b1;
                            end
                        end
                        else if (data_byte == CH_COLON)
                        begin
                            ns.line_phase = (s.name_matches && s.name_index == HDR_NAME_CHARS)
                                            ? PH_SKIP : PH_REST;
                        end
                        else
                        begin
                            if (s.name_index >= HDR_NAME_CHARS
                                || lower != name_char(s.name_index))
                            begin
                                ns.name_matches = 1'b0;
                            end
                            if (s.name_index < NAME_IDX_MAX)
                            begin
                                ns.name_index = s.name_index + 4'd1;
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        if (data_byte == CH_SPACE || data_byte == CH_TAB)
                        begin
                            ns.line_phase = PH_SKIP;
                        end
                        else if (is_digit)
                        begin
                            nlv             = LENGTH_BITS'(digit);
                            ns.length_found = 1'b1;
                            ns.line_phase   = PH_DIGITS;
                        end
                        else
                        begin
                            ns.length_bad = 1'b1;
                            ns.line_phase = PH_DONE;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            nlv = (times_ten[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                                  ? '1 : times_ten[LENGTH_BITS-1:0];
                        end
                        else
                        begin
                            ns.line_phase = PH_DONE;
                        end
                    end
                    PH_REST:
                    begin
                        if (line_end)
                        begin
                            ns.line_phase   = PH_NAME;
                            ns.name_index   = 4'd0;
                            ns.name_matches = 1'b1;
                        end
                    end
                    default:
                    begin
                        ns.line_phase = PH_DONE;
                    end
                endcase

                // Progress through CR LF CR LF.
                if (data_byte == CH_CR)
                begin
                    ns.crlf_match = (s.crlf_match == 2'd2) ? 2'd3 : 2'd1;
                end
                else if (data_byte == CH_LF && s.crlf_match == 2'd1)
                begin
                    ns.crlf_match = 2'd2;
                end
                else if (data_byte == CH_LF && s.crlf_match == 2'd3)
                begin
                    ns.crlf_match   = 2'd0;
                    ns.headers_done = 1'b1;
                    ns.body_start   = s.byte_count + 16'd1;
                end
                else
                begin
                    ns.crlf_match = 2'd0;
                end
            end

            // Completion checks on the updated state.
            need = NEED_BITS'(ns.body_start)
                 + (ns.length_found ? NEED_BITS'(nlv) : NEED_BITS'(0));
            if (ns.headers_done)
            begin
                if (ns.length_bad)
                begin
                    ns.final_status = ST_MALFORMED;
                end
                else if (NEED_BITS'(ns.byte_count) >= need)
                begin
                    ns.final_status = ST_COMPLETE;
                end
            end
            if (ns.final_status == ST_INCOMPLETE && ns.byte_count >= max_request_bytes)
            begin
                ns.final_status = ST_TOO_LONG;
            end
        end
    end

    assign next_state     = ns;
    assign next_length    = nlv;
    assign status         = ns.final_status;
    assign body_offset    = ns.headers_done ? ns.body_start : 16'd0;
    assign payload_length = (ns.headers_done && !ns.length_bad) ? nlv : '0;

endmodule

// File: rtl/hrlf_checker.sv
// Port-level checks of the HTTP request length framer, bound to the top level.
// Depends on hrlf_pkg and http_request_length_framer.
module hrlf_checker #(
    parameter int LENGTH_BITS = 20
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [((18+LENGTH_BITS+7)/8)*8-1:0] m_axis_tdata
);
    import hrlf_pkg::*;

    logic       s_xfer;
    logic [1:0] out_status;
    logic       out_len_zero;

    assign s_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_status   = m_axis_tdata[1:0];
    assign out_len_zero = (m_axis_tdata[17+LENGTH_BITS:18] == '0);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A malformed length never reports a length value.
    a_malformed_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_status == ST_MALFORMED |-> out_len_zero)
        else $error("malformed result carries a length");

    // An accepted byte reaches the result register when that register is empty.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer ##1 !m_axis_tvalid |=> m_axis_tvalid)
        else $error("accepted byte produced no result");

    // Input is refused only while a result is waiting.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back pressure");

endmodule

bind http_request_length_framer hrlf_checker #(
    .LENGTH_BITS (LENGTH_BITS)
) u_hrlf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
